/* sv/cle_pkg.sv */
// Shared widths, register indexes and constants of the CPU load estimator.
package cle_pkg;

  localparam int NUM_CPUS  = 8;
  localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  localparam int CPU_IDX_W  = 3;
  localparam int TIME_W     = 64;
  localparam int DELTA_W    = 32;
  localparam int LOAD_W     = 7;
  localparam int FREQ_W     = 22;
  localparam int LF_W       = 32;
  localparam int SR_W       = 31;
  localparam int PROD_W     = DELTA_W + LOAD_W;
  localparam int CNT_W      = $clog2(DELTA_W + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_FREQ      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_USE_FREQ_AVG  = CFG_IDX_W'(3);

  localparam logic [SR_W-1:0]   SAMPLING_RATE_RST = SR_W'(20000);
  localparam logic [FREQ_W-1:0] CUR_FREQ_RST      = FREQ_W'(0);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST      = FREQ_W'(1);

  localparam logic [LOAD_W-1:0] LOAD_FULL = LOAD_W'(100);

endpackage

/* sv/cle_if.sv */
// Handshake channels of the CPU load estimator: sample in, result out and register writes.
interface cle_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [cle_pkg::CPU_IDX_W-1:0] cpu_index;
  logic [cle_pkg::TIME_W-1:0]    idle_time_us;
  logic [cle_pkg::TIME_W-1:0]    wall_time_us;
  logic [cle_pkg::FREQ_W-1:0]    avg_freq;
  logic                         last_cpu;

  modport source (
    output valid, mode, cpu_index, idle_time_us, wall_time_us, avg_freq, last_cpu,
    input  ready
  );
  modport sink (
    input  valid, mode, cpu_index, idle_time_us, wall_time_us, avg_freq, last_cpu,
    output ready
  );
endinterface

interface cle_out_if;
  logic                       valid;
  logic                       ready;
  logic [cle_pkg::LOAD_W-1:0] cpu_load;
  logic [cle_pkg::LOAD_W-1:0] cpu_peak;
  logic [cle_pkg::LOAD_W-1:0] policy_load;
  logic [cle_pkg::LF_W-1:0]   policy_load_freq;
  logic [cle_pkg::LF_W-1:0]   scaled_load;
  logic                       pass_done;

  modport source (
    output valid, cpu_load, cpu_peak, policy_load, policy_load_freq, scaled_load, pass_done,
    input  ready
  );
  modport sink (
    input  valid, cpu_load, cpu_peak, policy_load, policy_load_freq, scaled_load, pass_done,
    output ready
  );
endinterface

interface cle_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cle_pkg::CFG_IDX_W-1:0]  index;
  logic [cle_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

/* sv/cpu_load_estimator.sv */
// Top level of the CPU load estimator: per-CPU load from counter deltas and policy maxima.
// One sample is taken at a time. A prime transaction goes straight to emitting its result; a zero or
// inverted wall delta skips the multiply and the divide; an ordinary sample passes through
// the restoring divider, which produces the 7-bit load one quotient bit per cycle. A sample
// marked last then uses the same divider to produce the 32-bit load at maximum frequency one
// bit per cycle. The result is offered in the same cycle as the input opens again, and it
// sits in an output register, so the next sample is accepted while the previous result
// waits to be taken. Only the low 32 bits of the stored counters take part in the deltas.
module cpu_load_estimator (
  input  logic  clk_i,
  input  logic  rst_ni,
  cle_cfg_if.sink   cfg_i,
  cle_in_if.sink    in_i,
  cle_out_if.source out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_BURST = 4'd4;
  localparam logic [3:0] S_FREQ  = 4'd5;
  localparam logic [3:0] S_LFMAX = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  localparam int LD = cle_pkg::LOAD_W;
  localparam int DW = cle_pkg::DELTA_W;
  localparam int FW = cle_pkg::FREQ_W;
  localparam int LW = cle_pkg::LF_W;
  localparam int PW = cle_pkg::PROD_W;

  function automatic logic [cle_pkg::CPU_W-1:0] wrap_cpu(
    input logic [cle_pkg::CPU_IDX_W-1:0] idx
  );
    logic [6:0] v;
    v = 7'(idx);
    for (int k = 0; k < 7; k++) begin
      if (v >= 7'(cle_pkg::NUM_CPUS)) begin
        v = v - 7'(cle_pkg::NUM_CPUS);
      end
    end
    return v[cle_pkg::CPU_W-1:0];
  endfunction

  // Configuration registers.
  logic [cle_pkg::SR_W-1:0] sr_q;
  logic [FW-1:0]            cur_freq_q;
  logic [FW-1:0]            max_freq_q;
  logic                     use_avg_q;

  // Per-CPU history.
  logic [DW-1:0] prev_idle_q [cle_pkg::NUM_CPUS];
  logic [DW-1:0] prev_wall_q [cle_pkg::NUM_CPUS];
  logic [LD-1:0] prev_load_q [cle_pkg::NUM_CPUS];

  // Running policy maxima.
  logic [LD-1:0] rml_q;
  logic [LW-1:0] rmlf_q;

  // Working registers of one sample.
  logic [3:0]                 state_q, state_d;
  logic [cle_pkg::CPU_W-1:0]  cpu_q;
  logic [DW-1:0]              d_idle_q;
  logic [DW-1:0]              d_wall_q;
  logic [DW-1:0]              diff_q;
  logic [FW-1:0]              freq_q;
  logic                       last_q;
  logic [LD-1:0]              load_q;
  logic [LD+FW-1:0]           lf_q;

  // Restoring divider: remainder, dividend shifting out as quotient shifts in.
  logic [DW-1:0]              rem_q;
  logic [DW-1:0]              dvd_q;
  logic [DW-1:0]              div_q;
  logic [cle_pkg::CNT_W-1:0]  cnt_q;
  logic                       final_op_q;

  // Result being built, and the output register.
  logic [LD-1:0] res_load_q, res_peak_q, res_pl_q;
  logic [LW-1:0] res_plf_q, res_scaled_q;
  logic          res_done_q;
  logic          out_valid_q;
  logic [LD-1:0] out_load_q, out_peak_q, out_pl_q;
  logic [LW-1:0] out_plf_q, out_scaled_q;
  logic          out_done_q;

  logic                      in_fire;
  logic [cle_pkg::CPU_W-1:0] in_cpu;
  logic [DW-1:0]             in_d_idle, in_d_wall;
  logic [DW:0]               div_cand;
  logic                      div_ge;
  logic [DW:0]               div_sub;
  logic [PW-1:0]             prod100;
  logic [LD-1:0]             cur_prev;
  logic                      burst;
  logic [LD-1:0]             load_fin, new_prev, peak_new, rml_new;
  logic [FW-1:0]             freq_sel;
  logic [LW-1:0]             plf_new;
  logic [LD+FW-1:0]          pl_cur;
  logic [FW-1:0]             divisor;
  logic                      slot_free;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_cpu      = wrap_cpu(in_i.cpu_index);
  assign in_d_idle   = in_i.idle_time_us[DW-1:0] - prev_idle_q[in_cpu];
  assign in_d_wall   = in_i.wall_time_us[DW-1:0] - prev_wall_q[in_cpu];

  assign div_cand = {rem_q, dvd_q[DW-1]};
  assign div_ge   = div_cand >= {1'b0, div_q};
  assign div_sub  = div_cand - {1'b0, div_q};
  assign prod100  = PW'(diff_q) * PW'(cle_pkg::LOAD_FULL);

  // A long gap followed by a drop keeps the earlier load once, then forgets it.
  assign cur_prev = prev_load_q[cpu_q];
  assign burst    = (d_wall_q > {sr_q, 1'b0}) && (load_q < cur_prev);
  assign load_fin = burst ? cur_prev : load_q;
  assign new_prev = burst ? '0 : load_q;
  assign peak_new = (load_fin > new_prev) ? load_fin : new_prev;
  assign rml_new  = (load_fin > rml_q) ? load_fin : rml_q;

  assign freq_sel = (freq_q != '0) ? freq_q : cur_freq_q;
  assign plf_new  = (use_avg_q && (LW'(lf_q) > rmlf_q)) ? LW'(lf_q) : rmlf_q;
  assign pl_cur   = (LD+FW)'(res_pl_q) * (LD+FW)'(cur_freq_q);
  assign divisor  = (max_freq_q != '0) ? max_freq_q : FW'(1);

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = in_i.mode ? S_EMIT : S_CHK;
        end
      end
      S_CHK: begin
        state_d = ((d_wall_q == '0) || (d_wall_q < d_idle_q)) ? S_BURST : S_MUL;
      end
      S_MUL:   state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == cle_pkg::CNT_W'(1)) begin
          state_d = final_op_q ? S_EMIT : S_BURST;
        end
      end
      S_BURST: state_d = S_FREQ;
      S_FREQ:  state_d = S_LFMAX;
      S_LFMAX: state_d = last_q ? S_SCALE : S_EMIT;
      S_SCALE: state_d = S_DIV;
      S_EMIT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= cle_pkg::SAMPLING_RATE_RST;
      cur_freq_q  <= cle_pkg::CUR_FREQ_RST;
      max_freq_q  <= cle_pkg::MAX_FREQ_RST;
      use_avg_q   <= 1'b0;
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rml_q       <= '0;
      rmlf_q      <= '0;
      for (int i = 0; i < cle_pkg::NUM_CPUS; i++) begin
        prev_idle_q[i] <= '0;
        prev_wall_q[i] <= '0;
        prev_load_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          cle_pkg::CFG_SAMPLING_RATE: sr_q       <= cfg_i.data[cle_pkg::SR_W-1:0];
          cle_pkg::CFG_CUR_FREQ:      cur_freq_q <= cfg_i.data[FW-1:0];
          cle_pkg::CFG_MAX_FREQ:      max_freq_q <= cfg_i.data[FW-1:0];
          cle_pkg::CFG_USE_FREQ_AVG:  use_avg_q  <= cfg_i.data[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        prev_idle_q[in_cpu] <= in_i.idle_time_us[DW-1:0];
        prev_wall_q[in_cpu] <= in_i.wall_time_us[DW-1:0];
        if (in_i.mode) begin
          prev_load_q[in_cpu] <= '0;
        end
      end

      if (state_q == S_BURST) begin
        prev_load_q[cpu_q] <= new_prev;
        rml_q              <= rml_new;
      end

      if (state_q == S_LFMAX) begin
        if (last_q) begin
          rml_q  <= '0;
          rmlf_q <= '0;
        end else begin
          rmlf_q <= plf_new;
        end
      end

      out_valid_q <= ((state_q == S_EMIT) && slot_free) || (out_valid_q && !out_o.ready);
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cpu_q        <= in_cpu;
          d_idle_q     <= in_d_idle;
          d_wall_q     <= in_d_wall;
          freq_q       <= in_i.avg_freq;
          last_q       <= in_i.last_cpu;
          res_load_q   <= '0;
          res_peak_q   <= '0;
          res_pl_q     <= rml_q;
          res_plf_q    <= rmlf_q;
          res_scaled_q <= '0;
          res_done_q   <= 1'b0;
        end
      end
      S_CHK: begin
        diff_q <= d_wall_q - d_idle_q;
        if (d_wall_q == '0) begin
          load_q <= prev_load_q[cpu_q];
        end else begin
          load_q <= d_idle_q[DW-1] ? cle_pkg::LOAD_FULL : '0;
        end
      end
      S_MUL: begin
        // The quotient never exceeds the full load, so the top bits seed the remainder.
        rem_q      <= prod100[PW-1:LD];
        dvd_q      <= {prod100[LD-1:0], (DW-LD)'(0)};
        div_q      <= d_wall_q;
        cnt_q      <= cle_pkg::CNT_W'(LD);
        final_op_q <= 1'b0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_sub[DW-1:0] : div_cand[DW-1:0];
        dvd_q <= {dvd_q[DW-2:0], div_ge};
        cnt_q <= cnt_q - cle_pkg::CNT_W'(1);
        if (cnt_q == cle_pkg::CNT_W'(1)) begin
          if (final_op_q) begin
            res_scaled_q <= {dvd_q[DW-2:0], div_ge};
          end else begin
            load_q <= {dvd_q[LD-2:0], div_ge};
          end
        end
      end
      S_BURST: begin
        load_q     <= load_fin;
        res_load_q <= load_fin;
        res_peak_q <= peak_new;
      end
      S_FREQ: begin
        lf_q <= (LD+FW)'(load_q) * (LD+FW)'(freq_sel);
      end
      S_LFMAX: begin
        res_pl_q   <= rml_q;
        res_plf_q  <= plf_new;
        res_done_q <= last_q;
      end
      S_SCALE: begin
        rem_q      <= '0;
        dvd_q      <= use_avg_q ? res_plf_q : DW'(pl_cur);
        div_q      <= DW'(divisor);
        cnt_q      <= cle_pkg::CNT_W'(DW);
        final_op_q <= 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load_q   <= res_load_q;
          out_peak_q   <= res_peak_q;
          out_pl_q     <= res_pl_q;
          out_plf_q    <= res_plf_q;
          out_scaled_q <= res_scaled_q;
          out_done_q   <= res_done_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.cpu_load         = out_load_q;
  assign out_o.cpu_peak         = out_peak_q;
  assign out_o.policy_load      = out_pl_q;
  assign out_o.policy_load_freq = out_plf_q;
  assign out_o.scaled_load      = out_scaled_q;
  assign out_o.pass_done        = out_done_q;

endmodule

/* sv/cle_checker.sv */
// Port-level checks of the CPU load estimator, bound to the top level.
module cle_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cle_pkg::LOAD_W-1:0] cpu_load_i,
  input logic [cle_pkg::LOAD_W-1:0] cpu_peak_i,
  input logic [cle_pkg::LOAD_W-1:0] policy_load_i,
  input logic [cle_pkg::LF_W-1:0]   scaled_load_i,
  input logic                       pass_done_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(cpu_load_i) && $stable(cpu_peak_i)
      && $stable(policy_load_i) && $stable(scaled_load_i) && $stable(pass_done_i))
    else $error("result payload changed while stalled");

  // One sample at a time: the input closes right after a transaction.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a sample is in progress");

  // The peak and the running maximum both include this load.
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cpu_peak_i >= cpu_load_i) && (policy_load_i >= cpu_load_i))
    else $error("peak or policy load below the CPU load");

  // The scaled load only appears when a pass closes.
  a_scaled_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pass_done_i |-> scaled_load_i == '0)
    else $error("scaled load reported outside the end of a pass");

endmodule

bind cpu_load_estimator cle_checker u_cle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .cpu_load_i    (out_o.cpu_load),
  .cpu_peak_i    (out_o.cpu_peak),
  .policy_load_i (out_o.policy_load),
  .scaled_load_i (out_o.scaled_load),
  .pass_done_i   (out_o.pass_done)
);
